/* src/gcis_pkg.sv */
// Shared types, constants and helper functions for the grid cell interval search core.
// Depends on nothing; every other file in src uses it through scoped names.
package gcis_pkg;

  localparam int MAX_CELLS    = 256;
  localparam int NODE_DEPTH   = 1024;  // power of two: entry indexes wrap by truncation
  localparam int GHOST_MARGIN = 3;
  localparam int NUM_AXES     = 3;

  localparam int IDX_W      = $clog2(NODE_DEPTH);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int NODE_WORDS = NUM_AXES * NODE_DEPTH;
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int STEPS      = $clog2(MAX_CELLS);

  localparam int CFG_CELLS_W = 9;
  localparam int CFG_ORG_W   = 10;
  localparam int COORD_W     = 32;
  localparam int RES_W       = 10;
  localparam int PADDR_W     = 5;

  localparam logic [COORD_W-1:0] SIGN_BIAS = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic               ACT_WRITE = 1'b0;
  localparam logic [1:0]         AXIS_NONE = 2'd3;
  localparam logic signed [RES_W-1:0] RES_BELOW = -RES_W'(1);

  typedef enum logic [2:0] {
    REG_CELLS_X = 3'd0,
    REG_CELLS_Y = 3'd1,
    REG_CELLS_Z = 3'd2,
    REG_ORG_X   = 3'd3,
    REG_ORG_Y   = 3'd4,
    REG_ORG_Z   = 3'd5
  } reg_idx_t;

  typedef logic [COORD_W-1:0] key_t;

  // One transaction as it moves down the pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    is_wr;
    logic [1:0]              axis;
    logic [IDX_W-1:0]        widx;
    key_t                    key;     // sign bit flipped: unsigned order is signed order
    logic [CNT_W-1:0]        cells;
    logic [CFG_ORG_W-1:0]    origin;
    logic [CNT_W-1:0]        lo;
    logic [CNT_W-1:0]        hi;
    logic [CNT_W-1:0]        mid;
    logic                    pend;    // a read of node[mid] is in flight
    logic                    done;    // answer settled by the bounds check
    logic signed [RES_W-1:0] res;
  } item_t;

  function automatic logic [CNT_W-1:0] eff_cells(input logic [CFG_CELLS_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) r = CNT_W'(1);
    else if (32'(c) > MAX_CELLS) r = CNT_W'(MAX_CELLS);
    else r = CNT_W'(c);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] node_addr(input logic [1:0] axis,
                                                   input logic [CFG_ORG_W-1:0] origin,
                                                   input logic [CNT_W-1:0] i);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'((32'(origin) + 32'(GHOST_MARGIN) + 32'(i)) % NODE_DEPTH);
    return {axis, idx};
  endfunction

  // Folds in the node value fetched for the pending midpoint.
  function automatic item_t resolve(input item_t it, input key_t rd);
    item_t o;
    o = it;
    if (it.pend) begin
      if (rd <= it.key) o.lo = it.mid;
      else o.hi = it.mid;
    end
    o.pend = 1'b0;
    return o;
  endfunction

  // Picks the next midpoint while the interval still spans more than one cell.
  function automatic item_t issue(input item_t it);
    item_t o;
    logic [CNT_W:0] sum;
    o = it;
    sum = {1'b0, it.lo} + {1'b0, it.hi};
    o.mid = sum[CNT_W:1];
    o.pend = !it.is_wr && !it.done && ((it.hi - it.lo) > CNT_W'(1));
    return o;
  endfunction

endpackage

/* src/grid_cell_interval_search_core.sv */
// Top level of the grid cell interval search core: configuration registers, entry stage,
// bisection pipeline and result register. Depends on gcis_pkg, gcis_bounds and gcis_step.
//
// The core keeps one ascending table of Q16.16 node coordinates per axis and answers, for a
// query position, the cell i of the tile with node[i] <= position < node[i+1]. A position
// below the first node gives -1 and one above the last node gives cells+1.
// Input transactions are offered on in_action/in_axis/in_node_index/in_coordinate with start
// and are taken at every rising edge where start is high and busy is low. A write transaction
// (action 0) stores a node and gives no result; a query (action 1) gives exactly one result.
// Transactions on axis three are dropped without effect.
// Throughput is one transaction per cycle: every pipeline stage owns a copy of the node tables,
// so each of the eight bisection reads plus the two bound reads has its own memory port, and
// writes travel down the same pipeline to keep every copy in order with the queries.
// A query's result passes the bounds stage, the bisection steps and the result register, then
// is on out_cell_index with out_valid high for one cycle. The receiver cannot stall the
// core, so nothing ever waits and busy is only raised while reset is held.
// Reset (rst_n low, synchronous) empties the pipeline and sets every cell count to one and
// every tile origin to zero; the node tables keep whatever they held and must be written
// before a query reads them. Configuration goes over the APB port at byte address 4*index;
// the user must change it only while no query is in flight, which the core does not enforce.
module grid_cell_interval_search_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [1:0]                          in_axis,
  input  logic [gcis_pkg::CFG_ORG_W-1:0]      in_node_index,
  input  logic signed [gcis_pkg::COORD_W-1:0] in_coordinate,
  output logic                                out_valid,
  output logic signed [gcis_pkg::RES_W-1:0]   out_cell_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gcis_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int LATENCY = gcis_pkg::STEPS + 2;

  logic [gcis_pkg::CFG_CELLS_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [gcis_pkg::CFG_ORG_W-1:0]   org_x_r, org_y_r, org_z_r;
  gcis_pkg::reg_idx_t               reg_idx;
  logic                             cfg_wr;

  gcis_pkg::item_t                  in_item;
  logic [gcis_pkg::CFG_CELLS_W-1:0] sel_cells;
  logic [gcis_pkg::CFG_ORG_W-1:0]   sel_org;
  gcis_pkg::item_t                  stage_item [0:gcis_pkg::STEPS];
  gcis_pkg::key_t                   stage_rd   [0:gcis_pkg::STEPS];
  gcis_pkg::item_t                  fin_item;
  logic                             out_valid_r;
  logic signed [gcis_pkg::RES_W-1:0] out_res_r;

  // ---------------------------------------------------------------- configuration
  assign pready  = 1'b1;
  assign reg_idx = gcis_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= gcis_pkg::CFG_CELLS_W'(1);
      cells_y_r <= gcis_pkg::CFG_CELLS_W'(1);
      cells_z_r <= gcis_pkg::CFG_CELLS_W'(1);
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gcis_pkg::REG_CELLS_X: cells_x_r <= pwdata[gcis_pkg::CFG_CELLS_W-1:0];
        gcis_pkg::REG_CELLS_Y: cells_y_r <= pwdata[gcis_pkg::CFG_CELLS_W-1:0];
        gcis_pkg::REG_CELLS_Z: cells_z_r <= pwdata[gcis_pkg::CFG_CELLS_W-1:0];
        gcis_pkg::REG_ORG_X:   org_x_r   <= pwdata[gcis_pkg::CFG_ORG_W-1:0];
        gcis_pkg::REG_ORG_Y:   org_y_r   <= pwdata[gcis_pkg::CFG_ORG_W-1:0];
        gcis_pkg::REG_ORG_Z:   org_z_r   <= pwdata[gcis_pkg::CFG_ORG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gcis_pkg::REG_CELLS_X: prdata = 32'(cells_x_r);
      gcis_pkg::REG_CELLS_Y: prdata = 32'(cells_y_r);
      gcis_pkg::REG_CELLS_Z: prdata = 32'(cells_z_r);
      gcis_pkg::REG_ORG_X:   prdata = 32'(org_x_r);
      gcis_pkg::REG_ORG_Y:   prdata = 32'(org_y_r);
      gcis_pkg::REG_ORG_Z:   prdata = 32'(org_z_r);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign busy = !rst_n;

  always_comb begin
    case (in_axis)
      2'd0: begin
        sel_cells = cells_x_r;
        sel_org   = org_x_r;
      end
      2'd1: begin
        sel_cells = cells_y_r;
        sel_org   = org_y_r;
      end
      default: begin
        sel_cells = cells_z_r;
        sel_org   = org_z_r;
      end
    endcase
  end

  // The coordinate is biased once here so that all later compares are unsigned.
  always_comb begin
    in_item        = '0;
    in_item.valid  = start && !busy && (in_axis != gcis_pkg::AXIS_NONE);
    in_item.is_wr  = (in_action == gcis_pkg::ACT_WRITE);
    in_item.axis   = in_axis;
    in_item.widx   = gcis_pkg::IDX_W'(32'(in_node_index) % gcis_pkg::NODE_DEPTH);
    in_item.key    = gcis_pkg::key_t'(in_coordinate) ^ gcis_pkg::SIGN_BIAS;
    in_item.cells  = gcis_pkg::eff_cells(sel_cells);
    in_item.origin = sel_org;
  end

  // ---------------------------------------------------------------- pipeline
  gcis_bounds u_bounds (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (in_item),
    .item_o (stage_item[0])
  );

  // The bounds stage leaves no read pending, so its data input is unused.
  assign stage_rd[0] = '0;

  for (genvar k = 0; k < gcis_pkg::STEPS; k++) begin : g_step
    gcis_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .item_i (stage_item[k]),
      .rd_i   (stage_rd[k]),
      .item_o (stage_item[k+1]),
      .rd_o   (stage_rd[k+1])
    );
  end

  // The last midpoint read is folded in here; after all steps lo is the answer.
  assign fin_item = gcis_pkg::resolve(stage_item[gcis_pkg::STEPS],
                                      stage_rd[gcis_pkg::STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_item.valid && !fin_item.is_wr;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= fin_item.done ? fin_item.res : gcis_pkg::RES_W'(fin_item.lo);
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_res_r;

  // ---------------------------------------------------------------- assertions
  a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action != gcis_pkg::ACT_WRITE && in_axis != gcis_pkg::AXIS_NONE)
      |-> ##LATENCY out_valid)
    else $error("accepted query produced no result at the fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_action != gcis_pkg::ACT_WRITE &&
                        in_axis != gcis_pkg::AXIS_NONE, LATENCY))
    else $error("result without a matching query transaction");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_index == gcis_pkg::RES_BELOW) ||
                  (out_cell_index >= 0 &&
                   out_cell_index <= gcis_pkg::RES_W'(gcis_pkg::MAX_CELLS + 1)))
    else $error("cell index outside the tile range");

  a_search_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_item.valid && !fin_item.is_wr && !fin_item.done) |->
      (fin_item.hi - fin_item.lo) == gcis_pkg::CNT_W'(1))
    else $error("bisection interval not closed after the last step");

endmodule

/* src/gcis_bounds.sv */
// Entry stage: node table copy with two read ports that fetches the first and last tile node,
// then classifies the query as below, above, on the last node, or inside. Uses gcis_pkg.
module gcis_bounds (
  input  logic           clk,
  input  logic           rst_n,
  input  gcis_pkg::item_t item_i,
  output gcis_pkg::item_t item_o
);

  gcis_pkg::key_t  mem [0:gcis_pkg::NODE_WORDS-1];
  gcis_pkg::item_t item_r;
  gcis_pkg::key_t  rd0_r;
  gcis_pkg::key_t  rdn_r;

  always_ff @(posedge clk) begin
    if (item_i.valid && item_i.is_wr) begin
      mem[{item_i.axis, item_i.widx}] <= item_i.key;
    end
    rd0_r <= mem[gcis_pkg::node_addr(item_i.axis, item_i.origin, '0)];
    rdn_r <= mem[gcis_pkg::node_addr(item_i.axis, item_i.origin, item_i.cells)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r <= item_i;
    end
  end

  always_comb begin
    item_o      = item_r;
    item_o.lo   = '0;
    item_o.hi   = item_r.cells;
    item_o.mid  = '0;
    item_o.pend = 1'b0;
    item_o.done = 1'b1;
    item_o.res  = gcis_pkg::RES_BELOW;
    if (item_r.key < rd0_r) begin
      item_o.res = gcis_pkg::RES_BELOW;
    end else if (item_r.key > rdn_r) begin
      item_o.res = gcis_pkg::RES_W'(item_r.cells) + gcis_pkg::RES_W'(1);
    end else if (item_r.key == rdn_r) begin
      item_o.res = gcis_pkg::RES_W'(item_r.cells);
    end else begin
      item_o.done = 1'b0;
    end
  end

endmodule

/* src/gcis_step.sv */
// One bisection stage with its own node table copy: folds in the previous midpoint read,
// picks the next midpoint and reads it. Uses gcis_pkg.
module gcis_step (
  input  logic            clk,
  input  logic            rst_n,
  input  gcis_pkg::item_t item_i,
  input  gcis_pkg::key_t  rd_i,
  output gcis_pkg::item_t item_o,
  output gcis_pkg::key_t  rd_o
);

  gcis_pkg::key_t  mem [0:gcis_pkg::NODE_WORDS-1];
  gcis_pkg::item_t item_nxt;
  gcis_pkg::item_t item_r;
  gcis_pkg::key_t  rd_r;

  assign item_nxt = gcis_pkg::issue(gcis_pkg::resolve(item_i, rd_i));

  // Writes land here in the cycle after the stage before, so every query sees
  // exactly the writes that were accepted ahead of it.
  always_ff @(posedge clk) begin
    if (item_nxt.valid && item_nxt.is_wr) begin
      mem[{item_nxt.axis, item_nxt.widx}] <= item_nxt.key;
    end
    rd_r <= mem[gcis_pkg::node_addr(item_nxt.axis, item_nxt.origin, item_nxt.mid)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;
  assign rd_o   = rd_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for grid_cell_interval_search_core: node table loads, cell queries
// and APB register phases. Depends on gcis_pkg and the core's RTL.

// Scoreboard: keeps a mirror of the node tables and registers and the queue of predicted
// cell indexes. Every query on axes zero to two pushes one prediction, and every strobed result pops one.
class cell_lookup_board;
  logic signed [31:0] nodes [3][gcis_pkg::NODE_DEPTH];
  logic [8:0]         cells [3];
  logic [9:0]         origin [3];
  logic signed [9:0]  expected_cells [$];
  int                 errors;
  int                 queries;
  int                 writes;

  function new();
    for (int a = 0; a < 3; a++) begin
      cells[a]  = 9'd1;
      origin[a] = 10'd0;
    end
    errors  = 0;
    queries = 0;
    writes  = 0;
  endfunction

  function void set_reg(gcis_pkg::reg_idx_t idx, logic [31:0] value);
    if (idx <= gcis_pkg::REG_CELLS_Z) cells[idx] = value[8:0];
    else origin[idx - gcis_pkg::REG_ORG_X] = value[9:0];
  endfunction

  // Effective cell count: zero acts as one, and counts above the maximum saturate.
  function int cell_count(int a);
    int c;
    c = cells[a];
    if (c == 0) c = 1;
    if (c > gcis_pkg::MAX_CELLS) c = gcis_pkg::MAX_CELLS;
    return c;
  endfunction

  function logic signed [31:0] node_of(int a, int i);
    return nodes[a][(origin[a] + gcis_pkg::GHOST_MARGIN + i) % gcis_pkg::NODE_DEPTH];
  endfunction

  function logic signed [9:0] locate_cell(int a, logic signed [31:0] pos);
    int c, lo, hi, mid;
    c  = cell_count(a);
    lo = 0;
    hi = c;
    if (pos < node_of(a, 0)) return -10'sd1;
    if (pos > node_of(a, c)) return 10'(c + 1);
    if (pos == node_of(a, c)) return 10'(c);
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (node_of(a, mid) <= pos) lo = mid;
      else hi = mid;
    end
    return 10'(lo);
  endfunction

  function void note_transaction(logic act, logic [1:0] axis, logic [9:0] idx,
                                 logic signed [31:0] coord);
    if (axis == gcis_pkg::AXIS_NONE) return;
    if (act == gcis_pkg::ACT_WRITE) begin
      nodes[axis][idx] = coord;
      writes++;
    end else begin
      expected_cells.push_back(locate_cell(axis, coord));
      queries++;
    end
  endfunction

  function void check_result(logic signed [9:0] got);
    logic signed [9:0] want;
    if (expected_cells.size() == 0) begin
      $error("cell_index: unexpected result %0d", got);
      errors++;
      return;
    end
    want = expected_cells.pop_front();
    if (got !== want) begin
      $error("cell_index: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_action;
  logic [1:0]         in_axis;
  logic [9:0]         in_node_index;
  logic signed [31:0] in_coordinate;
  logic               out_valid;
  logic signed [9:0]  out_cell_index;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [gcis_pkg::PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  cell_lookup_board board;
  int               cycles = 0;
  int               phases;

  grid_cell_interval_search_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_axis        (in_axis),
    .in_node_index  (in_node_index),
    .in_coordinate  (in_coordinate),
    .out_valid      (out_valid),
    .out_cell_index (out_cell_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results cannot be held off, so every strobed cycle is a transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_cell_index);
  end

  // Watchdog: a hung core or a lost handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** grid_cell_interval_search_core: FAILED **");
      $finish;
    end
  end

  // Offers one transaction. Called just after a falling edge and returns just after one.
  // A random gap with start low may come first; with no gap, start
  // simply stays high, so it is never lowered and raised in the same step.
  task automatic send_item(logic act, logic [1:0] axis, logic [9:0] idx,
                           logic signed [31:0] coord);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action     = act;
    in_axis       = axis;
    in_node_index = idx;
    in_coordinate = coord;
    start         = 1'b1;
    do @(posedge clk); while (busy);
    board.note_transaction(act, axis, idx, coord);
    @(negedge clk);
  endtask

  // Lets every outstanding query finish; writes give no result, so the task waits on past
  // the last one to let trailing writes through before anything is reconfigured.
  task automatic drain();
    start = 1'b0;
    while (board.expected_cells.size() != 0) @(negedge clk);
    repeat (14) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(gcis_pkg::reg_idx_t idx, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = gcis_pkg::PADDR_W'(4 * idx);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    board.set_reg(idx, value);
  endtask

  task automatic configure(logic [8:0] cx, logic [8:0] cy, logic [8:0] cz,
                           logic [9:0] ox, logic [9:0] oy, logic [9:0] oz);
    write_reg(gcis_pkg::REG_CELLS_X, {23'd0, cx});
    write_reg(gcis_pkg::REG_CELLS_Y, {23'd0, cy});
    write_reg(gcis_pkg::REG_CELLS_Z, {23'd0, cz});
    write_reg(gcis_pkg::REG_ORG_X, {22'd0, ox});
    write_reg(gcis_pkg::REG_ORG_Y, {22'd0, oy});
    write_reg(gcis_pkg::REG_ORG_Z, {22'd0, oz});
    phases++;
  endtask

  // A query aimed at the tile: mostly exactly on a node or one step either side of it,
  // which is where the interval edges are decided, and sometimes anywhere at all.
  task automatic random_query();
    logic [1:0]         axis;
    int                 i;
    logic signed [31:0] pos;
    axis = 2'($urandom_range(0, 2));
    i    = $urandom_range(0, board.cell_count(axis) + 1);
    pos  = board.node_of(axis, i);
    case ($urandom_range(0, 4))
      0: pos = pos - 1;
      1: pos = pos + 1;
      2: pos = $urandom;
      default: ;
    endcase
    send_item(~gcis_pkg::ACT_WRITE, axis, 10'($urandom), pos);
  endtask

  // A node rewrite inside the current tile: usually a small nudge that mostly keeps the
  // order, sometimes a wild value that leaves the table out of order, and now and then a
  // dropped axis-three transaction.
  task automatic random_write();
    logic [1:0]         axis;
    logic [9:0]         idx;
    logic signed [31:0] v;
    axis = 2'($urandom_range(0, 2));
    idx  = 10'((board.origin[axis] + gcis_pkg::GHOST_MARGIN +
                $urandom_range(0, board.cell_count(axis) + 1)) % gcis_pkg::NODE_DEPTH);
    v    = board.nodes[axis][idx] + $signed(32'($urandom_range(0, 2047)) - 32'sd1024);
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: axis = gcis_pkg::AXIS_NONE;
      default: ;
    endcase
    send_item(gcis_pkg::ACT_WRITE, axis, idx, v);
  endtask

  // Writes node j of an ascending ramp to the given entry of one axis.
  task automatic load_node(int a, int j, int idx);
    logic signed [31:0] base;
    base = $signed((j - 128) * 32'sh0010_0000) + $signed(32'($urandom_range(0, 32'h7FFFF)));
    send_item(gcis_pkg::ACT_WRITE, 2'(a), 10'(idx), base);
  endtask

  initial begin
    board         = new();
    phases        = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = gcis_pkg::ACT_WRITE;
    in_axis       = 2'd0;
    in_node_index = 10'd0;
    in_coordinate = 32'sd0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = 32'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Load ascending ramps over just the entries that the tile settings below can reach:
    // x entries 0 to 263, y entries 1016 up through the wrap to 23, z entries 0 to 31.
    for (int n = 0; n < 264; n++) load_node(0, n, n);
    for (int j = 0; j < 32; j++) load_node(1, j, (1016 + j) % gcis_pkg::NODE_DEPTH);
    for (int n = 0; n < 32; n++) load_node(2, n, n);

    // Directed: reset counts (one cell, origin zero), bounds, exact nodes, dropped axis.
    send_item(~gcis_pkg::ACT_WRITE, 2'd0, 10'd0, 32'sh8000_0000);
    send_item(~gcis_pkg::ACT_WRITE, 2'd1, 10'd1023, 32'sh7FFF_FFFF);
    send_item(~gcis_pkg::ACT_WRITE, 2'd2, 10'd0, board.node_of(2, 1));
    send_item(~gcis_pkg::ACT_WRITE, 2'd0, 10'd0, board.node_of(0, 0));
    send_item(~gcis_pkg::ACT_WRITE, 2'd1, 10'd0, board.node_of(1, 0) - 1);
    send_item(~gcis_pkg::ACT_WRITE, 2'd2, 10'd0, board.node_of(2, 1) - 1);
    send_item(~gcis_pkg::ACT_WRITE, gcis_pkg::AXIS_NONE, 10'd0, 32'sd0);
    send_item(gcis_pkg::ACT_WRITE, gcis_pkg::AXIS_NONE, 10'd3, 32'sh8000_0000);
    send_item(~gcis_pkg::ACT_WRITE, 2'd0, 10'd0, board.node_of(0, 0));
    // Extreme node values break the order of the table; the search must still settle.
    send_item(gcis_pkg::ACT_WRITE, 2'd0, 10'd1023, 32'sh7FFF_FFFF);
    send_item(gcis_pkg::ACT_WRITE, 2'd1, 10'd4, 32'sh8000_0000);
    send_item(gcis_pkg::ACT_WRITE, 2'd2, 10'd4, 32'sh7FFF_FFFF);
    send_item(~gcis_pkg::ACT_WRITE, 2'd1, 10'd0, 32'sd0);
    send_item(~gcis_pkg::ACT_WRITE, 2'd2, 10'd0, 32'sd0);
    send_item(~gcis_pkg::ACT_WRITE, 2'd2, 10'd0, 32'sh7FFF_FFFF);
    drain();

    // Register phases: largest tile, counts of zero and above the maximum, a y origin that
    // makes the entry index wrap, then random settings that stay inside the loaded entries.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(9'd256, 9'd16, 9'd8, 10'd0, 10'd1013, 10'd0);
        1: configure(9'd511, 9'd0, 9'd20, 10'd3, 10'd1020, 10'd5);
        2: configure(9'd1, 9'd2, 9'd3, 10'd200, 10'd1020, 10'd0);
        default: configure(9'($urandom_range(0, 16)), 9'($urandom_range(0, 16)),
                           9'($urandom_range(0, 24)), 10'($urandom_range(0, 243)),
                           10'($urandom_range(1013, 1023)), 10'($urandom_range(0, 3)));
      endcase
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 9) < 7) random_query();
        else random_write();
      end
      // The sender holds off here until every predicted result has come back.
      drain();
    end

    configure(9'd1, 9'd1, 9'd1, 10'd0, 10'd0, 10'd0);
    for (int k = 0; k < 10; k++) random_query();

    start = 1'b0;
    while (board.expected_cells.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d queries and %0d node writes over %0d register settings.",
             board.queries, board.writes, phases);
    if (board.errors == 0) begin
      $display("** grid_cell_interval_search_core: PASSED **");
    end else begin
      $display("** grid_cell_interval_search_core: FAILED **");
    end
    $finish;
  end
endmodule
